// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the FT1.2 frame checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define FT12_ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("FT1.2 checker assertion failed");

// Checks that a condition implies another one in the same cycle.
`define FT12_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("FT1.2 checker assertion failed");

`endif

// ===== rtl/ft12_pkg.sv =====
// ----------------------------------------------------------------------------
// FT1.2 frame checker package
// Shared constants and types for the FT1.2 frame checker.
// ----------------------------------------------------------------------------
`default_nettype none

package ft12_pkg;

  localparam logic [7:0] START_FIXED = 8'h10;
  localparam logic [7:0] START_VAR   = 8'h68;
  localparam logic [7:0] END_BYTE    = 8'h16;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_CSUM_ERR     = 2'd1,
    ST_LEN_MISMATCH = 2'd2,
    ST_BAD_END      = 2'd3
  } status_t;

  // Word held in the input register.
  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } stage_t;

endpackage

`default_nettype wire

// ===== rtl/ft12_rx_if.sv =====
// ----------------------------------------------------------------------------
// Receive byte channel
// Valid/ready channel that carries one received byte per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface ft12_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/ft12_res_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one classified byte per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface ft12_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       data_valid;
  logic       frame_end;
  logic       frame_kind;
  logic [1:0] frame_status;

  modport source (
    output valid, output data_byte, output data_valid, output frame_end,
    output frame_kind, output frame_status, input ready
  );
  modport sink (
    input valid, input data_byte, input data_valid, input frame_end,
    input frame_kind, input frame_status, output ready
  );
endinterface

`default_nettype wire

// ===== rtl/ft12_frame_checker.sv =====
// ----------------------------------------------------------------------------
// FT1.2 frame checker
// Classifies a received byte stream into IEC 60870-5 FT1.2 link frames.
// ----------------------------------------------------------------------------
// The block takes one received byte per cycle unless the result side stalls and
// returns one result word per byte. A byte sits in an input register, then a
// single step of the frame state machine with an 8-bit checksum adder
// classifies it into the result register, so a full byte rate is held while
// the result side keeps taking words. Fixed and variable frames are closed by
// byte count, and the status is reported on the end byte.
// The address length register may only be written while no byte is in flight.
`default_nettype none

`include "assert_macros.svh"

module ft12_frame_checker (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [1:0] cfg_wr_data,
  ft12_rx_if.sink         rx,
  ft12_res_if.source      res
);

  ft12_pkg::stage_t stage;
  logic             take;

  ft12_in_stage u_in_stage (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx),
    .take  (take),
    .stage (stage)
  );

  ft12_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .stage       (stage),
    .take        (take),
    .res         (res)
  );

  `FT12_ASSERT_IMPLIES(a_status_only_at_end, clk, rst,
    res.valid && !res.frame_end, res.frame_status == ft12_pkg::ST_OK)
  `FT12_ASSERT_IMPLIES(a_data_not_end, clk, rst,
    res.valid && res.data_valid, !res.frame_end)
  `FT12_ASSERT_IMPLIES(a_held_blocks_input, clk, rst,
    stage.valid && !take, !rx.ready)
  `FT12_ASSERT_ALWAYS(a_take_needs_word, clk, rst, !take || stage.valid)

endmodule

`default_nettype wire

// ===== rtl/ft12_in_stage.sv =====
// ----------------------------------------------------------------------------
// FT1.2 input register
// Holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ft12_in_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  ft12_rx_if.sink            rx,
  input  wire logic          take,
  output ft12_pkg::stage_t   stage
);

  logic       held;
  logic [7:0] held_byte;

  assign rx.ready      = !held || take;
  assign stage.valid   = held;
  assign stage.rx_byte = held_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      held <= 1'b1;
    end else if (take) begin
      held <= 1'b0;
    end
    if (rx.valid && rx.ready) begin
      held_byte <= rx.rx_byte;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ft12_parser.sv =====
// ----------------------------------------------------------------------------
// FT1.2 frame parser
// Steps the frame state by one byte and registers the classified result.
// ----------------------------------------------------------------------------
`default_nettype none

module ft12_parser (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wr_en,
  input  wire logic [1:0]       cfg_wr_data,
  input  wire ft12_pkg::stage_t stage,
  output logic                  take,
  ft12_res_if.source            res
);

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_BODY   = 3'd1,
    PH_LEN1   = 3'd2,
    PH_LEN2   = 3'd3,
    PH_START2 = 3'd4,
    PH_CSUM   = 3'd5,
    PH_END    = 3'd6
  } phase_t;

  logic [1:0] link_addr_len;
  phase_t     phase, phase_next;
  logic       kind_reg, kind_reg_next;
  logic [7:0] first_length, first_length_next;
  logic       length_bad, length_bad_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] running_sum, running_sum_next;
  logic       sum_bad, sum_bad_next;

  logic              r_valid;
  logic              r_end;
  logic              r_kind;
  ft12_pkg::status_t r_status;

  logic              out_valid;
  logic [7:0]        out_byte;
  logic              out_data_valid;
  logic              out_end;
  logic              out_kind;
  ft12_pkg::status_t out_status;

  logic [7:0] b;

  assign b    = stage.rx_byte;
  assign take = stage.valid && (!out_valid || res.ready);

  assign res.valid        = out_valid;
  assign res.data_byte    = out_byte;
  assign res.data_valid   = out_data_valid;
  assign res.frame_end    = out_end;
  assign res.frame_kind   = out_kind;
  assign res.frame_status = out_status;

  always_comb begin
    phase_next        = phase;
    kind_reg_next     = kind_reg;
    first_length_next = first_length;
    length_bad_next   = length_bad;
    bytes_left_next   = bytes_left;
    running_sum_next  = running_sum;
    sum_bad_next      = sum_bad;
    r_valid           = 1'b0;
    r_end             = 1'b0;
    r_kind            = kind_reg;
    r_status          = ft12_pkg::ST_OK;
    unique case (phase)
      PH_BODY: begin
        r_valid          = 1'b1;
        running_sum_next = running_sum + b;
        bytes_left_next  = bytes_left - 8'd1;
        if (bytes_left == 8'd1) begin
          phase_next = PH_CSUM;
        end
      end
      PH_LEN1: begin
        first_length_next = b;
        phase_next        = PH_LEN2;
      end
      PH_LEN2: begin
        length_bad_next = (b != first_length);
        phase_next      = PH_START2;
      end
      PH_START2: begin
        bytes_left_next = first_length;
        phase_next      = (first_length == 8'd0) ? PH_CSUM : PH_BODY;
      end
      PH_CSUM: begin
        sum_bad_next = (b != running_sum);
        phase_next   = PH_END;
      end
      PH_END: begin
        r_end = 1'b1;
        if (length_bad) begin
          r_status = ft12_pkg::ST_LEN_MISMATCH;
        end else if (sum_bad) begin
          r_status = ft12_pkg::ST_CSUM_ERR;
        end else if (b != ft12_pkg::END_BYTE) begin
          r_status = ft12_pkg::ST_BAD_END;
        end
        phase_next = PH_HUNT;
      end
      default: begin
        phase_next       = PH_HUNT;
        running_sum_next = 8'd0;
        sum_bad_next     = 1'b0;
        length_bad_next  = 1'b0;
        r_kind           = 1'b0;
        if (b == ft12_pkg::START_FIXED) begin
          kind_reg_next     = 1'b0;
          first_length_next = 8'd0;
          bytes_left_next   = {6'd0, link_addr_len} + 8'd1;
          phase_next        = PH_BODY;
        end else if (b == ft12_pkg::START_VAR) begin
          kind_reg_next = 1'b1;
          r_kind        = 1'b1;
          phase_next    = PH_LEN1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_addr_len <= 2'd1;
      phase         <= PH_HUNT;
      kind_reg      <= 1'b0;
      first_length  <= 8'd0;
      length_bad    <= 1'b0;
      bytes_left    <= 8'd0;
      running_sum   <= 8'd0;
      sum_bad       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        link_addr_len <= cfg_wr_data;
      end
      if (take) begin
        phase        <= phase_next;
        kind_reg     <= kind_reg_next;
        first_length <= first_length_next;
        length_bad   <= length_bad_next;
        bytes_left   <= bytes_left_next;
        running_sum  <= running_sum_next;
        sum_bad      <= sum_bad_next;
        out_valid    <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (take) begin
      out_byte       <= b;
      out_data_valid <= r_valid;
      out_end        <= r_end;
      out_kind       <= r_kind;
      out_status     <= r_status;
    end
  end

endmodule

`default_nettype wire
